### src/idql_pkg.sv
// Shared types and codes for the indexed deque list.
// Used by idql_cell and by the top level indexed_deque_list_core.
package idql_pkg;

  localparam int POS_W    = 5;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 32;
  localparam int OUT_CNTW = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_READ_AT    = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every storage cell.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic wr;
  } cell_ctl_t;

endpackage

### src/idql_cell.sv
// One storage cell of the entry chain: holds a single entry and loads it from
// its left neighbor, its right neighbor or the new data. Depends on idql_pkg.
module idql_cell import idql_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CMP_W = 5,
  parameter int EW    = 32
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CMP_W-1:0] pos,
  input  logic [EW-1:0]    wr_data,
  input  logic [EW-1:0]    left_data,
  input  logic [EW-1:0]    right_data,
  output logic [EW-1:0]    data
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;

  // Entries at and above an insert point move up; entries at and above an
  // erase point take the value of their upper neighbor.
  always_comb begin
    data_nxt = data_r;
    priority if (ctl.wr && (MY_IDX == pos)) begin
      data_nxt = wr_data;
    end else if (ctl.shift_up && (MY_IDX > pos)) begin
      data_nxt = left_data;
    end else if (ctl.shift_down && (MY_IDX >= pos)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### src/indexed_deque_list_core.sv
// Top level of the indexed deque list: operation decode, entry count, read
// select and result register around a chain of idql_cell instances.
// Depends on idql_pkg and idql_cell.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  operation, position, entry_data
//   out_     output     out_valid/out_stall read_data, entry_count, status
//
// All cells shift or load in parallel on the accepting edge, so one transaction
// is taken per clock while the input is not stalled.
// The result appears in the output register on the cycle after acceptance.
// Input is stalled only while a result is held in the output register and the
// output side stalls. Synchronous active-low reset empties the list; entry
// contents are not cleared and are never read before being written.
module indexed_deque_list_core import idql_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_operation,
  input  logic [POS_W-1:0]    in_position,
  input  logic [IN_DW-1:0]    in_entry_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_DW-1:0]   out_read_data,
  output logic [OUT_CNTW-1:0] out_entry_count,
  output logic [1:0]          out_status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                   accept;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_DW-1:0]      out_read_data_r;
  logic [OUT_CNTW-1:0]    out_entry_count_r;
  status_t                out_status_r;
  status_t                status_nxt;
  logic [ENTRY_WIDTH-1:0] rd_nxt;
  logic [ENTRY_WIDTH-1:0] rd_sel;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       cell_pos;
  logic                   is_full;
  logic                   is_empty;
  op_t                    op;
  cell_ctl_t              ctl;
  cell_ctl_t              ctl_dec;

  logic [ENTRY_WIDTH-1:0] cell_q     [DEPTH];
  logic [ENTRY_WIDTH-1:0] left_data  [DEPTH];
  logic [ENTRY_WIDTH-1:0] right_data [DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign op       = op_t'(in_operation);
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign wr_data  = ENTRY_WIDTH'(in_entry_data);
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // Read select over the cells; out-of-range reads are zeroed in the decode.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == pos_ext) begin
        rd_sel = cell_q[i];
      end
    end
  end

  always_comb begin
    ctl_dec    = '0;
    cell_pos   = pos_ext;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_dec.shift_up = 1'b1;
          ctl_dec.wr       = 1'b1;
          cell_pos         = '0;
          count_nxt        = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_dec.wr = 1'b1;
          cell_pos   = cnt_ext;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_dec.shift_up = 1'b1;
          ctl_dec.wr       = 1'b1;
          count_nxt        = count_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_RANGE;
        end else begin
          ctl_dec.shift_down = 1'b1;
          cell_pos           = '0;
          count_nxt          = count_r - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_ERASE_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          ctl_dec.shift_down = 1'b1;
          count_nxt          = count_r - CNT_W'(1);
        end
      end
      OP_READ_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = rd_sel;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign ctl = accept ? ctl_dec : '0;

  // Neighbor chain; cell 0's left is unused, the top cell's right is itself.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i] = wr_data;
    end else begin : g_left
      assign left_data[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data[i] = cell_q[i];
    end else begin : g_right
      assign right_data[i] = cell_q[i+1];
    end

    idql_cell #(
      .IDX   (i),
      .CMP_W (CMP_W),
      .EW    (ENTRY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (cell_pos),
      .wr_data    (wr_data),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .data       (cell_q[i])
    );
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data_r   <= OUT_DW'(rd_nxt);
      out_entry_count_r <= OUT_CNTW'(count_nxt);
      out_status_r      <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_entry_count = out_entry_count_r;
  assign out_status      = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds capacity");

  a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("entry count changed without a transaction");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r && (out_entry_count_r == OUT_CNTW'(count_r))))
    else $error("result count does not match stored count");

  a_rd_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_read_data_r == '0))
    else $error("nonzero read data on a failed transaction");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status_nxt == ST_FULL)) |-> is_full)
    else $error("full status while not full");

endmodule
